// ===== hdl/svps_pkg.sv =====
package svps_pkg;

  // Pump relay pulse length in milliseconds
  localparam logic [31:0] PULSE_MS = 32'd2000;

  // Valve phase codes
  localparam logic [2:0] PH_UNKNOWN = 3'd0;
  localparam logic [2:0] PH_OPENING = 3'd1;
  localparam logic [2:0] PH_OPEN    = 3'd2;
  localparam logic [2:0] PH_CLOSING = 3'd3;
  localparam logic [2:0] PH_CLOSED  = 3'd4;

  // Run modes
  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_ON       = 2'd1;
  localparam logic [1:0] MODE_AUTO     = 2'd2;
  localparam logic [1:0] MODE_CLEANING = 2'd3;

  // Item operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_RUN_MODE        = 3'd0;
  localparam logic [2:0] REG_WATER_SETPOINT  = 3'd1;
  localparam logic [2:0] REG_LEAD_MARGIN     = 3'd2;
  localparam logic [2:0] REG_VALVE_TRAVEL_MS = 3'd3;
  localparam logic [2:0] REG_PUMP_HOLD_MS    = 3'd4;
  localparam logic [2:0] REG_LEVEL_FULL      = 3'd5;
  localparam logic [2:0] REG_LEVEL_ECO       = 3'd6;
  localparam logic [2:0] REG_LEVEL_CLEANING  = 3'd7;

  localparam int unsigned PADDR_W = 5;

  typedef struct packed {
    logic [1:0]  run_mode;
    logic [9:0]  water_setpoint;
    logic [7:0]  lead_margin;
    logic [23:0] valve_travel_ms;
    logic [23:0] pump_hold_ms;
    logic [1:0]  level_full;
    logic [1:0]  level_eco;
    logic [1:0]  level_cleaning;
  } cfg_t;

  typedef struct packed {
    logic               operation;
    logic [31:0]        time_ms;
    logic signed [10:0] air_temp;
    logic signed [10:0] water_temp;
  } item_t;

  typedef struct packed {
    logic       valve_open_drive;
    logic       valve_close_drive;
    logic [3:0] pump_relay_pulse;
    logic [1:0] pump_level;
    logic [2:0] valve_state;
    logic       pump_known;
  } res_t;

endpackage

// ===== hdl/svps_if.sv =====
// Input item channel
interface svps_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [31:0]        time_ms;
  logic signed [10:0] air_temp;
  logic signed [10:0] water_temp;

  modport source (output valid, operation, time_ms, air_temp, water_temp, input ready);
  modport sink   (input valid, operation, time_ms, air_temp, water_temp, output ready);
endinterface

// Result channel
interface svps_out_if;
  logic       valid;
  logic       ready;
  logic       valve_open_drive;
  logic       valve_close_drive;
  logic [3:0] pump_relay_pulse;
  logic [1:0] pump_level;
  logic [2:0] valve_state;
  logic       pump_known;

  modport source (output valid, valve_open_drive, valve_close_drive, pump_relay_pulse,
                  pump_level, valve_state, pump_known, input ready);
  modport sink   (input valid, valve_open_drive, valve_close_drive, pump_relay_pulse,
                  pump_level, valve_state, pump_known, output ready);
endinterface

// ===== hdl/svps_cfg_regs.sv =====
module svps_cfg_regs
  import svps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.run_mode        <= MODE_OFF;
      cfg_q.water_setpoint  <= 10'd400;
      cfg_q.lead_margin     <= 8'd32;
      cfg_q.valve_travel_ms <= 24'd60000;
      cfg_q.pump_hold_ms    <= 24'd60000;
      cfg_q.level_full      <= 2'd3;
      cfg_q.level_eco       <= 2'd1;
      cfg_q.level_cleaning  <= 2'd3;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_RUN_MODE:        cfg_q.run_mode        <= pwdata[1:0];
        REG_WATER_SETPOINT:  cfg_q.water_setpoint  <= pwdata[9:0];
        REG_LEAD_MARGIN:     cfg_q.lead_margin     <= pwdata[7:0];
        REG_VALVE_TRAVEL_MS: cfg_q.valve_travel_ms <= pwdata[23:0];
        REG_PUMP_HOLD_MS:    cfg_q.pump_hold_ms    <= pwdata[23:0];
        REG_LEVEL_FULL:      cfg_q.level_full      <= pwdata[1:0];
        REG_LEVEL_ECO:       cfg_q.level_eco       <= pwdata[1:0];
        REG_LEVEL_CLEANING:  cfg_q.level_cleaning  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    case (paddr[4:2])
      REG_RUN_MODE:        prdata = {30'd0, cfg_q.run_mode};
      REG_WATER_SETPOINT:  prdata = {22'd0, cfg_q.water_setpoint};
      REG_LEAD_MARGIN:     prdata = {24'd0, cfg_q.lead_margin};
      REG_VALVE_TRAVEL_MS: prdata = {8'd0, cfg_q.valve_travel_ms};
      REG_PUMP_HOLD_MS:    prdata = {8'd0, cfg_q.pump_hold_ms};
      REG_LEVEL_FULL:      prdata = {30'd0, cfg_q.level_full};
      REG_LEVEL_ECO:       prdata = {30'd0, cfg_q.level_eco};
      REG_LEVEL_CLEANING:  prdata = {30'd0, cfg_q.level_cleaning};
      default:             prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/svps_core.sv =====
module svps_core
  import svps_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  item_t item_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  localparam logic [1:0] GOAL_NONE  = 2'd0;
  localparam logic [1:0] GOAL_LARGE = 2'd1;
  localparam logic [1:0] GOAL_SMALL = 2'd2;

  // Controller state
  logic [2:0]  phase_q, phase_d;
  logic        moving_q, moving_d;
  logic [31:0] vstart_q, vstart_d;
  logic        open_q, open_d;
  logic        close_q, close_d;
  logic [1:0]  level_q, level_d;
  logic        known_q, known_d;
  logic        pulse_q, pulse_d;
  logic [1:0]  plevel_q, plevel_d;
  logic [31:0] pstart_q, pstart_d;
  logic [31:0] last_q, last_d;

  logic [31:0]        now;
  logic               temps_ok;
  logic signed [11:0] air_margin;
  logic               want_large, want_small;
  logic               drive;
  logic [1:0]         goal;
  logic               travel_busy;
  logic [2:0]         phase_mid;
  logic [1:0]         req_level;
  logic               req_ok;

  assign now = item_i.time_ms;

  // Goal selection from mode and temperatures
  always_comb begin
    temps_ok   = ~item_i.air_temp[10] & ~item_i.water_temp[10];
    air_margin = {item_i.air_temp[10], item_i.air_temp} - $signed({4'd0, cfg_i.lead_margin});
    want_large = (air_margin > $signed({item_i.water_temp[10], item_i.water_temp}))
                 && (item_i.water_temp[9:0] < cfg_i.water_setpoint);
    want_small = (item_i.air_temp <= item_i.water_temp) || (phase_q == PH_UNKNOWN);
    drive = 1'b1;
    goal  = GOAL_NONE;
    case (cfg_i.run_mode)
      MODE_ON:                 goal = GOAL_LARGE;
      MODE_OFF, MODE_CLEANING: goal = GOAL_SMALL;
      default: begin
        drive = temps_ok;
        if (want_large) begin
          goal = GOAL_LARGE;
        end else if (want_small) begin
          goal = GOAL_SMALL;
        end
      end
    endcase
  end

  // Travel timing, finishing a due travel, pump request gate
  always_comb begin
    travel_busy = moving_q && ((now - vstart_q) <= {8'd0, cfg_i.valve_travel_ms});
    phase_mid = phase_q;
    if (phase_q == PH_OPENING) begin
      phase_mid = PH_OPEN;
    end else if (phase_q == PH_CLOSING) begin
      phase_mid = PH_CLOSED;
    end
    if (goal == GOAL_LARGE) begin
      req_level = cfg_i.level_full;
    end else if (cfg_i.run_mode == MODE_CLEANING) begin
      req_level = cfg_i.level_cleaning;
    end else begin
      req_level = cfg_i.level_eco;
    end
    req_ok = ~pulse_q
             && !(known_q && (level_q == req_level))
             && !(known_q && ((now - last_q) <= {8'd0, cfg_i.pump_hold_ms}));
  end

  // Next state
  always_comb begin
    phase_d  = phase_q;
    moving_d = moving_q;
    vstart_d = vstart_q;
    open_d   = open_q;
    close_d  = close_q;
    level_d  = level_q;
    known_d  = known_q;
    pulse_d  = pulse_q;
    plevel_d = plevel_q;
    pstart_d = pstart_q;
    last_d   = last_q;
    if (item_i.operation == OP_TICK) begin
      if (pulse_q && ((now - pstart_q) >= PULSE_MS)) begin
        pulse_d = 1'b0;
        last_d  = now;
      end
    end else if (drive && !travel_busy) begin
      if (phase_mid != phase_q) begin
        open_d   = 1'b0;
        close_d  = 1'b0;
        moving_d = 1'b0;
      end
      phase_d = phase_mid;
      if (goal == GOAL_LARGE && phase_mid != PH_OPEN) begin
        open_d   = 1'b1;
        close_d  = 1'b0;
        vstart_d = now;
        moving_d = 1'b1;
        phase_d  = PH_OPENING;
      end
      if (goal == GOAL_SMALL && phase_mid != PH_CLOSED) begin
        open_d   = 1'b0;
        close_d  = 1'b1;
        vstart_d = now;
        moving_d = 1'b1;
        phase_d  = PH_CLOSING;
      end
      if (goal != GOAL_NONE && req_ok) begin
        level_d  = req_level;
        known_d  = 1'b1;
        pulse_d  = 1'b1;
        plevel_d = req_level;
        pstart_d = now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_UNKNOWN;
      moving_q <= 1'b0;
      vstart_q <= '0;
      open_q   <= 1'b0;
      close_q  <= 1'b0;
      level_q  <= '0;
      known_q  <= 1'b0;
      pulse_q  <= 1'b0;
      plevel_q <= '0;
      pstart_q <= '0;
      last_q   <= '0;
    end else if (en_i) begin
      phase_q  <= phase_d;
      moving_q <= moving_d;
      vstart_q <= vstart_d;
      open_q   <= open_d;
      close_q  <= close_d;
      level_q  <= level_d;
      known_q  <= known_d;
      pulse_q  <= pulse_d;
      plevel_q <= plevel_d;
      pstart_q <= pstart_d;
      last_q   <= last_d;
    end
  end

  // Result reflects the state after the transaction
  always_comb begin
    res_o.valve_open_drive  = open_d;
    res_o.valve_close_drive = close_d;
    res_o.pump_relay_pulse  = pulse_d ? (4'b0001 << plevel_d) : 4'b0000;
    res_o.pump_level        = level_d;
    res_o.valve_state       = phase_d;
    res_o.pump_known        = known_d;
  end

endmodule

// ===== hdl/solar_valve_pump_sequencer_unit.sv =====
// Solar valve and pump sequencer. Every input transaction (a tick or a control
// evaluation) yields exactly one result transaction carrying the relay drives,
// pump pulse, pump level and valve phase after that item. One transaction is
// accepted per clock while the result is not stalled; it passes the input
// register, then the single state-update stage loading the result register.
// That one state-update stage is what sets the rate of one item per cycle; a
// stalled result holds the input register, and input ready drops only once
// both registers are occupied.
// Configuration goes through the APB port at byte address 4*index and should
// only be written while no transaction is in flight.
module solar_valve_pump_sequencer_unit
  import svps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  svps_in_if.sink            in_i,
  svps_out_if.source         out_o
);

  cfg_t  cfg;
  item_t item_q;
  logic  in_vld_q;
  res_t  res, res_q;
  logic  out_vld_q;
  logic  advance;

  svps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline flow control
  assign advance    = in_vld_q & (~out_vld_q | out_o.ready);
  assign in_i.ready = ~in_vld_q | advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.operation  <= in_i.operation;
      item_q.time_ms    <= in_i.time_ms;
      item_q.air_temp   <= in_i.air_temp;
      item_q.water_temp <= in_i.water_temp;
    end
  end

  svps_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.valve_open_drive  = res_q.valve_open_drive;
  assign out_o.valve_close_drive = res_q.valve_close_drive;
  assign out_o.pump_relay_pulse  = res_q.pump_relay_pulse;
  assign out_o.pump_level        = res_q.pump_level;
  assign out_o.valve_state       = res_q.valve_state;
  assign out_o.pump_known        = res_q.pump_known;

endmodule

// ===== tb/sv/tb_solar_valve_pump_sequencer_unit.sv =====
module tb_solar_valve_pump_sequencer_unit;
  import svps_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ROUNDS = 12;
  localparam int ROUND_ITEMS  = 100;

  typedef enum logic [1:0] {LOOP_KEEP, LOOP_LARGE, LOOP_SMALL} loop_goal_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  svps_in_if  in_if ();
  svps_out_if out_if ();

  solar_valve_pump_sequencer_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_if),
    .out_o   (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Register mirror and sequencer state as the predictor sees it
  cfg_t        regs;
  logic [2:0]  v_phase    = PH_UNKNOWN;
  logic        v_moving   = 1'b0;
  logic [31:0] v_start    = '0;
  logic        open_on    = 1'b0;
  logic        close_on   = 1'b0;
  logic [1:0]  lvl_now    = '0;
  logic        lvl_known  = 1'b0;
  logic        pulse_on   = 1'b0;
  logic [1:0]  pulse_lvl  = '0;
  logic [31:0] pulse_t0   = '0;
  logic [31:0] last_lvl_t = '0;

  item_t       item_backlog[$];
  res_t        predicted_drives[$];
  int          items_queued = 0;
  int          items_taken  = 0;
  int          failures     = 0;
  bit          steady_flow  = 1'b0;
  logic [31:0] clock_ms     = '0;

  // Pump level request, ignored while a pulse runs, when that level is already set, or inside the hold window
  function automatic void request_pump_level(logic [1:0] lvl, logic [31:0] now);
    logic [31:0] since_change;
    since_change = now - last_lvl_t;
    if (pulse_on) return;
    if (lvl_known && lvl_now == lvl) return;
    if (lvl_known && since_change <= {8'd0, regs.pump_hold_ms}) return;
    lvl_now   = lvl;
    lvl_known = 1'b1;
    pulse_on  = 1'b1;
    pulse_lvl = lvl;
    pulse_t0  = now;
  endfunction

  // Finish a due travel, then head for the wanted loop
  function automatic void steer_valve(loop_goal_e goal, logic [31:0] now);
    logic [31:0] moved_ms;
    moved_ms = now - v_start;
    if (v_moving && moved_ms <= {8'd0, regs.valve_travel_ms}) return;
    if (v_phase == PH_OPENING || v_phase == PH_CLOSING) begin
      open_on  = 1'b0;
      close_on = 1'b0;
      v_phase  = (v_phase == PH_OPENING) ? PH_OPEN : PH_CLOSED;
      v_moving = 1'b0;
    end
    if (goal == LOOP_LARGE) begin
      if (v_phase != PH_OPEN) begin
        open_on  = 1'b1;
        close_on = 1'b0;
        v_start  = now;
        v_moving = 1'b1;
        v_phase  = PH_OPENING;
      end
      request_pump_level(regs.level_full, now);
    end else if (goal == LOOP_SMALL) begin
      if (v_phase != PH_CLOSED) begin
        close_on = 1'b1;
        open_on  = 1'b0;
        v_start  = now;
        v_moving = 1'b1;
        v_phase  = PH_CLOSING;
      end
      request_pump_level(regs.run_mode == MODE_CLEANING ? regs.level_cleaning
                                                        : regs.level_eco, now);
    end
  endfunction

  // Relay and pump state after one item
  function automatic res_t predict_drives(item_t it);
    res_t        r;
    int          air;
    int          water;
    logic [31:0] pulse_age;
    air   = $signed(it.air_temp);
    water = $signed(it.water_temp);
    if (it.operation == OP_TICK) begin
      pulse_age = it.time_ms - pulse_t0;
      if (pulse_on && pulse_age >= PULSE_MS) begin
        pulse_on   = 1'b0;
        last_lvl_t = it.time_ms;
      end
    end else if (regs.run_mode == MODE_ON) begin
      steer_valve(LOOP_LARGE, it.time_ms);
    end else if (regs.run_mode == MODE_OFF || regs.run_mode == MODE_CLEANING) begin
      steer_valve(LOOP_SMALL, it.time_ms);
    end else if (air >= 0 && water >= 0) begin
      if (air - int'(regs.lead_margin) > water && water < int'(regs.water_setpoint)) begin
        steer_valve(LOOP_LARGE, it.time_ms);
      end else if (air <= water || v_phase == PH_UNKNOWN) begin
        steer_valve(LOOP_SMALL, it.time_ms);
      end else begin
        steer_valve(LOOP_KEEP, it.time_ms);
      end
    end
    r.valve_open_drive  = open_on;
    r.valve_close_drive = close_on;
    r.pump_relay_pulse  = pulse_on ? (4'b0001 << pulse_lvl) : 4'b0000;
    r.pump_level        = lvl_now;
    r.valve_state       = v_phase;
    r.pump_known        = lvl_known;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0d, got %0d", name, want, seen);
      failures++;
    end
  endfunction

  // Input driver: holds each transaction until the block takes it
  always @(posedge clk_i) begin
    item_t taken;
    item_t next_item;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        taken.operation  = in_if.operation;
        taken.time_ms    = in_if.time_ms;
        taken.air_temp   = in_if.air_temp;
        taken.water_temp = in_if.water_temp;
        predicted_drives.push_back(predict_drives(taken));
        items_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (item_backlog.size() > 0 && (steady_flow || $urandom_range(99) >= 16)) begin
          next_item         = item_backlog.pop_front();
          in_if.valid      <= 1'b1;
          in_if.operation  <= next_item.operation;
          in_if.time_ms    <= next_item.time_ms;
          in_if.air_temp   <= next_item.air_temp;
          in_if.water_temp <= next_item.water_temp;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_drives.size() == 0) begin
          $error("result transaction with nothing outstanding");
          failures++;
        end else begin
          want = predicted_drives.pop_front();
          check_field("valve_open_drive", 32'(want.valve_open_drive),
                      32'(out_if.valve_open_drive));
          check_field("valve_close_drive", 32'(want.valve_close_drive),
                      32'(out_if.valve_close_drive));
          check_field("pump_relay_pulse", 32'(want.pump_relay_pulse),
                      32'(out_if.pump_relay_pulse));
          check_field("pump_level", 32'(want.pump_level), 32'(out_if.pump_level));
          check_field("valve_state", 32'(want.valve_state), 32'(out_if.valve_state));
          check_field("pump_known", 32'(want.pump_known), 32'(out_if.pump_known));
        end
      end
      out_if.ready <= steady_flow || ($urandom_range(99) >= 16);
    end
  end

  // APB write: setup then access, mirror updated once the access completes
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RUN_MODE:        regs.run_mode        = value[1:0];
      REG_WATER_SETPOINT:  regs.water_setpoint  = value[9:0];
      REG_LEAD_MARGIN:     regs.lead_margin     = value[7:0];
      REG_VALVE_TRAVEL_MS: regs.valve_travel_ms = value[23:0];
      REG_PUMP_HOLD_MS:    regs.pump_hold_ms    = value[23:0];
      REG_LEVEL_FULL:      regs.level_full      = value[1:0];
      REG_LEVEL_ECO:       regs.level_eco       = value[1:0];
      REG_LEVEL_CLEANING:  regs.level_cleaning  = value[1:0];
      default: ;
    endcase
  endtask

  function automatic void queue_item(logic op, logic [31:0] t, int air, int water);
    item_t it;
    it.operation  = op;
    it.time_ms    = t;
    it.air_temp   = air[10:0];
    it.water_temp = water[10:0];
    item_backlog.push_back(it);
    items_queued++;
    clock_ms = t;
  endfunction

  // Sender holds off until every result is back; checked off the active edge
  task automatic wait_quiet();
    @(negedge clk_i);
    while (items_taken != items_queued || predicted_drives.size() != 0) @(negedge clk_i);
  endtask

  // Mostly plausible temperatures and short time steps, some noise and wraps
  function automatic void queue_random_items(int n);
    int          pick;
    int          air;
    int          water;
    logic        op;
    logic [31:0] t;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60)      t = clock_ms + $urandom_range(1200);
      else if (pick < 85) t = clock_ms + $urandom_range(9000);
      else if (pick < 95) t = clock_ms + $urandom_range(70000);
      else if (pick < 98) t = clock_ms + $urandom;
      else                t = $urandom;
      op   = ($urandom_range(99) < 45) ? OP_TICK : OP_EVAL;
      pick = $urandom_range(99);
      if (pick < 80) begin
        water = $urandom_range(700);
        air   = water + int'($urandom_range(400)) - 150;
        if (air < 0) air = 0;
        if (air > 1023) air = 1023;
      end else if (pick < 92) begin
        air   = $urandom_range(1) ? -int'($urandom_range(1, 1024)) : int'($urandom_range(1023));
        water = $urandom_range(1) ? -int'($urandom_range(1, 1024)) : int'($urandom_range(1023));
      end else begin
        air   = $urandom_range(2047);
        water = $urandom_range(2047);
      end
      queue_item(op, t, air, water);
    end
  endfunction

  // One register setting per round, extremes on the early rounds
  task automatic configure_round(int p);
    logic [1:0]  mode;
    logic [31:0] setpoint;
    logic [31:0] margin;
    logic [31:0] travel;
    logic [31:0] hold;
    mode     = (p % 3 == 2) ? MODE_AUTO : 2'(p % 4);
    setpoint = (p == 1) ? 160 : (p == 2) ? 560 : (p == 4) ? 0 : (p == 5) ? 1023
             : 160 + $urandom_range(400);
    margin   = (p == 1) ? 1 : (p == 2) ? 160 : (p == 4) ? 0 : (p == 5) ? 255
             : 1 + $urandom_range(159);
    travel = (p == 1) ? 0 : (p == 2) ? 32'hFF_FFFF : (p == 7) ? $urandom_range(24'hFF_FFFF)
           : $urandom_range(5000);
    hold   = (p == 1) ? 0 : (p == 3) ? 32'hFF_FFFF : (p == 8) ? $urandom_range(24'hFF_FFFF)
           : $urandom_range(8000);
    write_reg(REG_RUN_MODE, {30'd0, mode});
    write_reg(REG_WATER_SETPOINT, setpoint);
    write_reg(REG_LEAD_MARGIN, margin);
    write_reg(REG_VALVE_TRAVEL_MS, travel);
    write_reg(REG_PUMP_HOLD_MS, hold);
    write_reg(REG_LEVEL_FULL, (p == 1) ? 0 : (p == 2) ? 3 : $urandom_range(3));
    write_reg(REG_LEVEL_ECO, (p == 1) ? 0 : (p == 2) ? 3 : $urandom_range(3));
    write_reg(REG_LEVEL_CLEANING, (p == 1) ? 0 : (p == 2) ? 3 : $urandom_range(3));
  endtask

  // Run watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    regs = '{MODE_OFF, 10'd400, 8'd32, 24'd60000, 24'd60000, 2'd3, 2'd1, 2'd3};
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.operation  = OP_TICK;
    in_if.time_ms    = '0;
    in_if.air_temp   = '0;
    in_if.water_temp = '0;
    out_if.ready     = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Automatic from an unknown valve, pulse end at exactly 2000 ms, invalid data
    write_reg(REG_RUN_MODE, {30'd0, MODE_AUTO});
    @(negedge clk_i);
    queue_item(OP_EVAL, 32'd100, 200, 190);
    queue_item(OP_TICK, 32'd2099, 0, 0);
    queue_item(OP_TICK, 32'd2100, 0, 0);
    queue_item(OP_EVAL, 32'd30000, -1024, -1024);
    queue_item(OP_EVAL, 32'd60100, 0, 0);
    queue_item(OP_EVAL, 32'd60101, 1023, 1023);
    wait_quiet();

    // Large loop: travel still running, pulse in progress, then settled
    write_reg(REG_RUN_MODE, {30'd0, MODE_ON});
    write_reg(REG_VALVE_TRAVEL_MS, 1000);
    write_reg(REG_PUMP_HOLD_MS, 500);
    write_reg(REG_LEVEL_FULL, 2);
    @(negedge clk_i);
    queue_item(OP_EVAL, 32'd70000, 0, 0);
    queue_item(OP_EVAL, 32'd70500, 0, 0);
    queue_item(OP_EVAL, 32'd71001, 0, 0);
    queue_item(OP_TICK, 32'd71999, 0, 0);
    queue_item(OP_TICK, 32'd72000, 0, 0);
    wait_quiet();

    // Automatic: invalid sensors, dead band, level change held back by the hold time
    write_reg(REG_RUN_MODE, {30'd0, MODE_AUTO});
    @(negedge clk_i);
    queue_item(OP_EVAL, 32'd72100, -1, 100);
    queue_item(OP_EVAL, 32'd72150, 300, -5);
    queue_item(OP_EVAL, 32'd72200, 200, 150);
    queue_item(OP_EVAL, 32'd72250, 160, 150);
    queue_item(OP_EVAL, 32'd72300, 100, 150);
    queue_item(OP_EVAL, 32'd73400, 100, 150);
    queue_item(OP_EVAL, 32'd73500, 500, 450);
    queue_item(OP_TICK, 32'd75400, 0, 0);
    wait_quiet();

    // Cleaning with zero travel, pulse timed across the 32-bit wrap
    write_reg(REG_RUN_MODE, {30'd0, MODE_CLEANING});
    write_reg(REG_LEVEL_CLEANING, 0);
    write_reg(REG_VALVE_TRAVEL_MS, 0);
    @(negedge clk_i);
    queue_item(OP_EVAL, 32'hFFFF_FF00, 0, 0);
    queue_item(OP_TICK, 32'h0000_06CF, 0, 0);
    queue_item(OP_TICK, 32'h0000_06D0, 0, 0);
    wait_quiet();

    // Random rounds, one without any idling on either side
    for (int p = 0; p < RANDOM_ROUNDS; p++) begin
      configure_round(p);
      @(negedge clk_i);
      steady_flow = (p == 6);
      queue_random_items(ROUND_ITEMS);
      wait_quiet();
    end
    steady_flow = 1'b0;

    repeat (8) @(posedge clk_i);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/svps_pkg.sv
hdl/svps_if.sv
hdl/svps_cfg_regs.sv
hdl/svps_core.sv
hdl/solar_valve_pump_sequencer_unit.sv
tb/sv/tb_solar_valve_pump_sequencer_unit.sv
